/* rtl/core/bcc_pkg.sv */
// Package for the bank conflict counter: field widths, register indexes
// and parameter defaults. No dependencies.
package bcc_pkg;

    // Parameter defaults for the top level.
    localparam int DEF_BANKS         = 32;
    localparam int DEF_COUNT_WIDTH   = 8;
    localparam int DEF_ADDRESS_WIDTH = 32;

    // Request and result field widths.
    localparam int ADDR_FIELD_W  = 32;
    localparam int BANK_IDX_W    = 5;
    localparam int USES_W        = 8;
    localparam int WORST_W       = 8;
    localparam int M_TDATA_RAW_W = BANK_IDX_W + USES_W + WORST_W;
    localparam int M_TDATA_W     = ((M_TDATA_RAW_W + 7) / 8) * 8;

    // Configuration port and registers.
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int BANK_COUNT_W = 6;
    localparam int UNIT_W       = 16;
    // Wide enough for both the bank count register and the largest bank parameter.
    localparam int CLAMP_W      = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_BANK_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT       = CFG_INDEX_W'(1);

    localparam logic [BANK_COUNT_W-1:0] BANK_COUNT_RST = BANK_COUNT_W'(32);
    localparam logic [UNIT_W-1:0]       UNIT_RST       = UNIT_W'(1);

endpackage

/* rtl/core/bank_conflict_counter.sv */
// Top level of the bank conflict counter: divider, bank count memory,
// result register and configuration registers. Depends on bcc_pkg.
//
// Usage:
//   Each request on the s_ channel carries one element address (s_tdata),
//   an address-valid flag (s_tuser) and a group-end mark (s_tlast). The
//   block computes bank = (address / elements_per_bank_unit) mod bank_count,
//   raises that bank's count (saturating) and tracks the group maximum.
//   Each request gives one result on the m_ channel; m_tlast repeats the
//   group-end mark, after which all counts and the maximum clear. The cfg_
//   channel writes bank_count (index 0) and elements_per_bank_unit (index 1),
//   ignores other indexes and is always ready.
// Sequence:
//   With DW = min(ADDRESS_WIDTH, 32), a counted request passes through an
//   accept step, DW radix-2 divider steps (folding each quotient bit modulo
//   the bank count), one count memory read and one update. A skipped request
//   goes from accept straight to the update. A new request is taken only
//   after the previous one has left the update step.
// Reset and stall:
//   aresetn (synchronous, active low) clears all counts and the maximum at
//   once and restores the register defaults. A stalled result waits in the
//   output register; the next request is still accepted and computed, then
//   holds in its final step, with s_tready low, until the register frees up.
module bank_conflict_counter #(
    parameter int BANKS         = bcc_pkg::DEF_BANKS,
    parameter int COUNT_WIDTH   = bcc_pkg::DEF_COUNT_WIDTH,
    parameter int ADDRESS_WIDTH = bcc_pkg::DEF_ADDRESS_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bcc_pkg::ADDR_FIELD_W-1:0] s_tdata,  // [31:0] address
    input  logic                             s_tuser,  // [0] address_valid
    input  logic                             s_tlast,  // group_end
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [4:0] bank_index, [12:5] bank_uses, [20:13] worst_conflict, rest zero
    output logic [bcc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tuser,  // [0] counted
    output logic                             m_tlast,  // report_last
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bcc_pkg::*;

    localparam int DW    = (ADDRESS_WIDTH < ADDR_FIELD_W) ? ADDRESS_WIDTH : ADDR_FIELD_W;
    localparam int STEPW = $clog2(DW + 1);
    localparam int BIW   = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int BCW   = $clog2(BANKS + 1);
    localparam int CW    = COUNT_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t                  state_reg;
    logic [BANK_COUNT_W-1:0] bank_count_reg;
    logic [UNIT_W-1:0]       unit_reg;

    logic [DW-1:0]           shift_reg;
    logic [UNIT_W-1:0]       rem_reg;
    logic [BIW-1:0]          bank_reg;
    logic [BCW-1:0]          banks_reg;
    logic [UNIT_W-1:0]       div_reg;
    logic [STEPW-1:0]        step_reg;
    logic                    counted_reg;
    logic                    last_reg;

    logic [BANKS-1:0]        entry_vld_reg;
    logic [CW-1:0]           max_reg;
    logic [CW-1:0]           cnt_mem [BANKS];
    logic [CW-1:0]           cnt_rd_reg;

    logic                    out_vld_reg;
    logic [M_TDATA_W-1:0]    out_data_reg;
    logic [M_TDATA_W-1:0]    out_data_next;
    logic                    out_user_reg;
    logic                    out_last_reg;

    logic [CLAMP_W-1:0]      bc_ext;
    logic [CLAMP_W-1:0]      banks_clamp;
    logic [UNIT_W-1:0]       unit_eff;

    logic [UNIT_W:0]         rem_shift;
    logic                    q_bit;
    logic [UNIT_W-1:0]       rem_next;
    logic [BIW:0]            mod_shift;
    logic [BIW:0]            banks_ext;
    logic [BIW-1:0]          bank_next;

    logic [CW-1:0]           cnt_cur;
    logic [CW-1:0]           cnt_new;
    logic [CW-1:0]           max_new;
    logic                    out_free;
    logic                    out_load;
    logic                    in_fire;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_vld_reg || m_tready;
    assign out_load  = (state_reg == ST_UPDATE) && out_free;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Register values out of range are pulled into range when a request starts.
    always_comb begin
        bc_ext = CLAMP_W'(bank_count_reg);
        if (bc_ext == '0) begin
            banks_clamp = CLAMP_W'(1);
        end else if (bc_ext > CLAMP_W'(BANKS)) begin
            banks_clamp = CLAMP_W'(BANKS);
        end else begin
            banks_clamp = bc_ext;
        end
        unit_eff = (unit_reg == '0) ? UNIT_W'(1) : unit_reg;
    end

    // One restoring division step. Each quotient bit, which arrives MSB
    // first, is folded straight into the running remainder modulo the bank
    // count, so the quotient itself is never stored.
    always_comb begin
        rem_shift = {rem_reg, shift_reg[DW-1]};
        q_bit     = (rem_shift >= {1'b0, div_reg});
        rem_next  = q_bit ? UNIT_W'(rem_shift - {1'b0, div_reg}) : UNIT_W'(rem_shift);
        mod_shift = {bank_reg, q_bit};
        banks_ext = (BIW + 1)'(banks_reg);
        bank_next = (mod_shift >= banks_ext) ? BIW'(mod_shift - banks_ext) : BIW'(mod_shift);
    end

    // Count update from the registered memory read; an entry cleared since
    // its last write reads as zero.
    always_comb begin
        cnt_cur = entry_vld_reg[bank_reg] ? cnt_rd_reg : '0;
        cnt_new = (cnt_cur == {CW{1'b1}}) ? cnt_cur : CW'(cnt_cur + 1'b1);
        max_new = (cnt_new > max_reg) ? cnt_new : max_reg;
    end

    always_comb begin
        out_data_next = '0;
        if (counted_reg) begin
            out_data_next[BANK_IDX_W-1:0]                  = BANK_IDX_W'(bank_reg);
            out_data_next[BANK_IDX_W +: USES_W]            = USES_W'(cnt_new);
            out_data_next[BANK_IDX_W + USES_W +: WORST_W]  = WORST_W'(max_new);
        end else begin
            out_data_next[BANK_IDX_W + USES_W +: WORST_W]  = WORST_W'(max_reg);
        end
    end

    // Bank count memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPDATE && out_free && counted_reg) begin
            cnt_mem[bank_reg] <= cnt_new;
        end
        cnt_rd_reg <= cnt_mem[bank_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bank_count_reg <= BANK_COUNT_RST;
            unit_reg       <= UNIT_RST;
            entry_vld_reg  <= '0;
            max_reg        <= '0;
            out_vld_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_BANK_COUNT: bank_count_reg <= cfg_data[BANK_COUNT_W-1:0];
                    REG_UNIT:       unit_reg       <= cfg_data[UNIT_W-1:0];
                    default: ;
                endcase
            end

            if (m_tready && !out_load) begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        shift_reg   <= s_tdata[DW-1:0];
                        rem_reg     <= '0;
                        bank_reg    <= '0;
                        banks_reg   <= BCW'(banks_clamp);
                        div_reg     <= unit_eff;
                        step_reg    <= STEPW'(DW);
                        counted_reg <= s_tuser;
                        last_reg    <= s_tlast;
                        state_reg   <= s_tuser ? ST_DIVIDE : ST_UPDATE;
                    end
                end
                ST_DIVIDE: begin
                    shift_reg <= shift_reg << 1;
                    rem_reg   <= rem_next;
                    bank_reg  <= bank_next;
                    step_reg  <= step_reg - 1'b1;
                    if (step_reg == STEPW'(1)) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    // The memory read at the final bank is registered in this state.
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (out_free) begin
                        out_vld_reg  <= 1'b1;
                        out_user_reg <= counted_reg;
                        out_last_reg <= last_reg;
                        out_data_reg <= out_data_next;
                        if (last_reg) begin
                            entry_vld_reg <= '0;
                            max_reg       <= '0;
                        end else if (counted_reg) begin
                            entry_vld_reg[bank_reg] <= 1'b1;
                            max_reg                 <= max_new;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
